[hdl/assert_macros.svh]
// Assertion helpers for the RTL, included by the decoder unit top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, suspended while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clock edge, including during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/tpwbd_pkg.sv]
package tpwbd_pkg;

   // Field widths
   localparam int WIDTH_W     = 8;
   localparam int COUNT_W     = 4;
   localparam int BUF_W       = 16;
   localparam int POS_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int BYTE_BITS   = 8;

   // Leftover bit keeps only the upper byte of the buffer
   localparam logic [BUF_W-1:0] KEEP_MASK = 16'hFF00;

   // Saturation limit of the pulse counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_SHORT,
      CLS_MEDIUM,
      CLS_LONG
   } pulse_class_type;

   typedef enum logic {
      CMD_DECODE  = 1'b0,
      CMD_RESTART = 1'b1
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SHORT_CENTER  = 2'd0,
      REG_MEDIUM_CENTER = 2'd1,
      REG_LONG_CENTER   = 2'd2,
      REG_TOLERANCE     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] short_center;
      logic [WIDTH_W-1:0] medium_center;
      logic [WIDTH_W-1:0] long_center;
      logic [WIDTH_W-1:0] tolerance;
   } window_cfg_type;

   typedef struct packed {
      logic               command;
      logic [WIDTH_W-1:0] pulse_width;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic [COUNT_W-1:0]   pulse_count;
      logic                 read_error;
   } rsp_word_type;

endpackage

[hdl/tpwbd_if.sv]
// Input channel: one pulse width or a restart command per word
interface tpwbd_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [tpwbd_pkg::WIDTH_W-1:0] pulse_width;

   modport source (output valid, output command, output pulse_width, input ready);
   modport sink   (input valid, input command, input pulse_width, output ready);
endinterface

// Result channel: one decoded byte or one error per word
interface tpwbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpwbd_pkg::BYTE_BITS-1:0] data_byte;
   logic [tpwbd_pkg::COUNT_W-1:0]   pulse_count;
   logic                          read_error;

   modport source (output valid, output data_byte, output pulse_count, output read_error,
                   input ready);
   modport sink   (input valid, input data_byte, input pulse_count, input read_error,
                   output ready);
endinterface

// Register write channel
interface tpwbd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tpwbd_pkg::CSR_INDEX_W-1:0] index;
   logic [tpwbd_pkg::WIDTH_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/tpwbd_classify.sv]
// Window compare: class of one pulse width, long over medium over short
module tpwbd_classify (
   input  logic [tpwbd_pkg::WIDTH_W-1:0] pulse_width,
   input  tpwbd_pkg::window_cfg_type     cfg,
   output tpwbd_pkg::pulse_class_type    pulse_class
);

   logic hit_short;
   logic hit_medium;
   logic hit_long;

   // Open window center +/- tolerance, compared at 9 bits so nothing wraps
   function automatic logic in_window(input logic [tpwbd_pkg::WIDTH_W-1:0] p,
                                      input logic [tpwbd_pkg::WIDTH_W-1:0] c,
                                      input logic [tpwbd_pkg::WIDTH_W-1:0] t);
      logic [tpwbd_pkg::WIDTH_W:0] p_plus_t;
      logic [tpwbd_pkg::WIDTH_W:0] c_plus_t;
      p_plus_t  = {1'b0, p} + {1'b0, t};
      c_plus_t  = {1'b0, c} + {1'b0, t};
      in_window = (p_plus_t > {1'b0, c}) && ({1'b0, p} < c_plus_t);
   endfunction

   assign hit_short  = in_window(pulse_width, cfg.short_center,  cfg.tolerance);
   assign hit_medium = in_window(pulse_width, cfg.medium_center, cfg.tolerance);
   assign hit_long   = in_window(pulse_width, cfg.long_center,   cfg.tolerance);

   // Priority select
   always_comb begin
      if (hit_long) begin
         pulse_class = tpwbd_pkg::CLS_LONG;
      end else if (hit_medium) begin
         pulse_class = tpwbd_pkg::CLS_MEDIUM;
      end else if (hit_short) begin
         pulse_class = tpwbd_pkg::CLS_SHORT;
      end else begin
         pulse_class = tpwbd_pkg::CLS_NONE;
      end
   end

endmodule

[hdl/tpwbd_core.sv]
// Reader state, bit packer and result register
module tpwbd_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  logic                       command,
   input  tpwbd_pkg::pulse_class_type pulse_class,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output tpwbd_pkg::rsp_word_type    rsp_word
);

   logic                            phase_two_ff, phase_two_in;
   logic [tpwbd_pkg::POS_W-1:0]     bit_position_ff, bit_position_in;
   logic [tpwbd_pkg::BUF_W-1:0]     bit_buffer_ff, bit_buffer_in;
   logic [tpwbd_pkg::COUNT_W-1:0]   pulses_used_ff, pulses_used_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tpwbd_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                            emit;
   logic                            two_bits;
   logic [1:0]                      code;
   logic [tpwbd_pkg::BUF_W-1:0]     aligned;
   logic [tpwbd_pkg::BUF_W-1:0]     merged;
   logic [tpwbd_pkg::POS_W-1:0]     pos_sum;
   logic [tpwbd_pkg::COUNT_W-1:0]   pulses_inc;

   // Phase machine table: class and phase to bit count and code
   always_comb begin
      two_bits = 1'b0;
      code     = 2'b00;
      case (pulse_class)
         tpwbd_pkg::CLS_SHORT: begin
            two_bits = 1'b0;
            code     = phase_two_ff ? 2'b00 : 2'b01;
         end
         tpwbd_pkg::CLS_MEDIUM: begin
            two_bits = !phase_two_ff;
            code     = phase_two_ff ? 2'b01 : 2'b00;
         end
         tpwbd_pkg::CLS_LONG: begin
            two_bits = 1'b1;
            code     = phase_two_ff ? 2'b00 : 2'b01;
         end
         default: begin
            two_bits = 1'b0;
            code     = 2'b00;
         end
      endcase
   end

   // Align the new bits to the top of the buffer, then shift to the fill point
   assign aligned    = two_bits ? {code, {(tpwbd_pkg::BUF_W-2){1'b0}}}
                                : {code[0], {(tpwbd_pkg::BUF_W-1){1'b0}}};
   assign merged     = bit_buffer_ff | (aligned >> bit_position_ff);
   assign pos_sum    = bit_position_ff + (two_bits ? 4'd2 : 4'd1);
   assign pulses_inc = (pulses_used_ff < tpwbd_pkg::COUNT_MAX) ? pulses_used_ff + 4'd1
                                                               : pulses_used_ff;

   // Next state and result word
   always_comb begin
      phase_two_in    = phase_two_ff;
      bit_position_in = bit_position_ff;
      bit_buffer_in   = bit_buffer_ff;
      pulses_used_in  = pulses_used_ff;
      emit            = 1'b0;
      rsp_word_in     = rsp_word_ff;

      if (fire) begin
         if (command == tpwbd_pkg::CMD_RESTART) begin
            phase_two_in    = 1'b0;
            bit_position_in = '0;
            bit_buffer_in   = '0;
            pulses_used_in  = '0;
         end else if (pulse_class == tpwbd_pkg::CLS_NONE) begin
            emit                    = 1'b1;
            rsp_word_in.data_byte   = '0;
            rsp_word_in.pulse_count = pulses_used_ff;
            rsp_word_in.read_error  = 1'b1;
            pulses_used_in          = '0;
         end else begin
            if (pulse_class == tpwbd_pkg::CLS_MEDIUM) begin
               phase_two_in = !phase_two_ff;
            end
            if (pos_sum >= 4'(tpwbd_pkg::BYTE_BITS)) begin
               emit                    = 1'b1;
               rsp_word_in.data_byte   = merged[tpwbd_pkg::BUF_W-1 -: tpwbd_pkg::BYTE_BITS];
               rsp_word_in.pulse_count = pulses_inc;
               rsp_word_in.read_error  = 1'b0;
               bit_buffer_in   = (merged << tpwbd_pkg::BYTE_BITS) & tpwbd_pkg::KEEP_MASK;
               bit_position_in = pos_sum - 4'(tpwbd_pkg::BYTE_BITS);
               pulses_used_in  = '0;
            end else begin
               bit_buffer_in   = merged;
               bit_position_in = pos_sum;
               pulses_used_in  = pulses_inc;
            end
         end
      end
   end

   // Result register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_two_ff    <= 1'b0;
         bit_position_ff <= '0;
         bit_buffer_ff   <= '0;
         pulses_used_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_two_ff    <= phase_two_in;
         bit_position_ff <= bit_position_in;
         bit_buffer_ff   <= bit_buffer_in;
         pulses_used_ff  <= pulses_used_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[hdl/tape_pulse_width_byte_decoder_unit.sv]
// An accepted input word passes the input register and then the result register before its result is valid.
// Throughput: one input word per cycle unless the result register stalls; the reader state
// updates in one pass through the window compare and bit packer between input and result registers.
// A stalled result register holds the input register; both then take one word each.
// Reset (synchronous, active high) clears valid flags, windows, phase, bit buffer and counts, not word payloads.
`include "assert_macros.svh"

module tape_pulse_width_byte_decoder_unit (
   input logic             clock,
   input logic             reset,
   tpwbd_req_if.sink       req_bus,
   tpwbd_rsp_if.source     rsp_bus,
   tpwbd_csr_if.sink       csr_bus
);

   tpwbd_pkg::window_cfg_type  cfg_ff, cfg_in;
   logic                       stage_valid_ff, stage_valid_in;
   tpwbd_pkg::req_word_type    stage_word_ff, stage_word_in;
   tpwbd_pkg::pulse_class_type pulse_class;
   tpwbd_pkg::rsp_word_type    rsp_word;
   logic                       rsp_valid;
   logic                       advance;
   logic                       fire;
   logic                       req_take;

   // Configuration registers
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (tpwbd_pkg::csr_index_type'(csr_bus.index))
            tpwbd_pkg::REG_SHORT_CENTER:  cfg_in.short_center  = csr_bus.data;
            tpwbd_pkg::REG_MEDIUM_CENTER: cfg_in.medium_center = csr_bus.data;
            tpwbd_pkg::REG_LONG_CENTER:   cfg_in.long_center   = csr_bus.data;
            tpwbd_pkg::REG_TOLERANCE:     cfg_in.tolerance     = csr_bus.data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register: moves on whenever the result register can take a word
   assign advance       = !rsp_valid || rsp_bus.ready;
   assign fire          = stage_valid_ff && advance;
   assign req_bus.ready = !stage_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      stage_word_in = stage_word_ff;
      if (req_take) begin
         stage_valid_in            = 1'b1;
         stage_word_in.command     = req_bus.command;
         stage_word_in.pulse_width = req_bus.pulse_width;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_word_ff <= stage_word_in;
   end

   tpwbd_classify u_classify (
      .pulse_width (stage_word_ff.pulse_width),
      .cfg         (cfg_ff),
      .pulse_class (pulse_class)
   );

   tpwbd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .command     (stage_word_ff.command),
      .pulse_class (pulse_class),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word)
   );

   // Result channel
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.data_byte   = rsp_word.data_byte;
   assign rsp_bus.pulse_count = rsp_word.pulse_count;
   assign rsp_bus.read_error  = rsp_word.read_error;

   // Checks
   `ASSERT_CLK(a_error_zero_byte, clock, reset, (rsp_bus.valid && rsp_bus.read_error) |-> (rsp_bus.data_byte == '0), "error word carries a nonzero byte")
   `ASSERT_CLK(a_count_bound, clock, reset, rsp_bus.valid |-> (rsp_bus.pulse_count <= 4'(tpwbd_pkg::BYTE_BITS)), "pulse count above one byte")
   `ASSERT_CLK(a_restart_silent, clock, reset, (fire && (stage_word_ff.command == tpwbd_pkg::CMD_RESTART)) |=> !rsp_bus.valid, "restart produced a result word")
   `ASSERT_CLK(a_stage_held, clock, reset, (stage_valid_ff && !advance) |=> (stage_valid_ff && $stable(stage_word_ff)), "stalled input word lost")

endmodule

[verif/tape_pulse_width_byte_decoder_unit_tb.sv]
`timescale 1ns / 100ps

module tape_pulse_width_byte_decoder_unit_tb;
   import tpwbd_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 93;
   localparam int SETTLE_CYCLES = 4;
   localparam int FINAL_CYCLES  = 8;

   // One row of the directed table: a window setting or one input word
   typedef struct {
      bit                   is_csr;
      window_cfg_type       windows;
      command_type          command;
      logic [WIDTH_W-1:0]   pulse_width;
      bit                   typed;
      bit                   has_result;
      rsp_word_type         result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   tpwbd_req_if req_bus ();
   tpwbd_rsp_if rsp_bus ();
   tpwbd_csr_if csr_bus ();

   always #1 clock = ~clock;

   tape_pulse_width_byte_decoder_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Decoder model state
   window_cfg_type       pred_windows;
   logic                 pred_phase_two;
   logic [POS_W-1:0]     pred_bit_pos;
   logic [BUF_W-1:0]     pred_bit_buf;
   logic [COUNT_W-1:0]   pred_pulses;

   rsp_word_type expected_bytes[$];
   stim_row_type directed_rows[$];

   // Hand-typed expectation riding along with the word on the bus
   bit           typed_hold;
   bit           typed_has;
   rsp_word_type typed_word;

   window_cfg_type phase_cfg;
   int burst_left = 0;
   int failures = 0;
   int words_sent = 0;
   int restarts_sent = 0;
   int bytes_seen = 0;
   int errors_seen = 0;
   int window_loads = 0;

   function automatic bit falls_in(input int p, input int c);
      int t;
      t = int'(pred_windows.tolerance);
      return (p > c - t) && (p < c + t);
   endfunction

   // Restart, or class the pulse, map it to bits and pack them; gives a byte, an error or no word
   function automatic void decode_pulse(input logic cmd, input logic [WIDTH_W-1:0] pw,
                                        output bit produced, output rsp_word_type word);
      pulse_class_type cls;
      int unsigned     nbits;
      int unsigned     val;
      int unsigned     pos;
      logic [31:0]     merged;
      produced = 1'b0;
      word     = '0;
      if (cmd == CMD_RESTART) begin
         pred_phase_two = 1'b0;
         pred_bit_pos   = '0;
         pred_bit_buf   = '0;
         pred_pulses    = '0;
         return;
      end

      // later windows win on overlap
      cls = CLS_NONE;
      if (falls_in(int'(pw), int'(pred_windows.short_center)))  cls = CLS_SHORT;
      if (falls_in(int'(pw), int'(pred_windows.medium_center))) cls = CLS_MEDIUM;
      if (falls_in(int'(pw), int'(pred_windows.long_center)))   cls = CLS_LONG;

      // no window: error, partial bits kept
      if (cls == CLS_NONE) begin
         produced         = 1'b1;
         word.pulse_count = pred_pulses;
         word.read_error  = 1'b1;
         pred_pulses      = '0;
         return;
      end

      if (!pred_phase_two) begin
         case (cls)
            CLS_SHORT:  begin nbits = 1; val = 1; end
            CLS_MEDIUM: begin nbits = 2; val = 0; pred_phase_two = 1'b1; end
            default:    begin nbits = 2; val = 1; end
         endcase
      end else begin
         case (cls)
            CLS_SHORT:  begin nbits = 1; val = 0; end
            CLS_MEDIUM: begin nbits = 1; val = 1; pred_phase_two = 1'b0; end
            default:    begin nbits = 2; val = 0; end
         endcase
      end

      merged = 32'(pred_bit_buf) | (((val << (BUF_W - nbits)) >> pred_bit_pos) & 32'hFFFF);
      pos    = pred_bit_pos + nbits;
      if (pred_pulses < COUNT_MAX) pred_pulses++;

      if (pos >= BYTE_BITS) begin
         produced         = 1'b1;
         word.data_byte   = merged[15:8];
         word.pulse_count = pred_pulses;
         word.read_error  = 1'b0;
         pred_bit_buf     = BUF_W'(merged << BYTE_BITS) & KEEP_MASK;
         pred_bit_pos     = POS_W'(pos - BYTE_BITS);
         pred_pulses      = '0;
      end else begin
         pred_bit_buf = merged[15:0];
         pred_bit_pos = POS_W'(pos);
      end
   endfunction

   function automatic stim_row_type item_row(input command_type cmd,
                                             input logic [WIDTH_W-1:0] pw,
                                             input bit typed, input bit has,
                                             input logic [BYTE_BITS-1:0] data,
                                             input logic [COUNT_W-1:0] count,
                                             input logic err);
      stim_row_type row;
      row.is_csr             = 1'b0;
      row.windows            = '0;
      row.command            = cmd;
      row.pulse_width        = pw;
      row.typed              = typed;
      row.has_result         = has;
      row.result.data_byte   = data;
      row.result.pulse_count = count;
      row.result.read_error  = err;
      return row;
   endfunction

   function automatic stim_row_type window_row(input logic [WIDTH_W-1:0] s,
                                               input logic [WIDTH_W-1:0] m,
                                               input logic [WIDTH_W-1:0] l,
                                               input logic [WIDTH_W-1:0] t);
      stim_row_type row;
      row.is_csr                = 1'b1;
      row.windows.short_center  = s;
      row.windows.medium_center = m;
      row.windows.long_center   = l;
      row.windows.tolerance     = t;
      row.command               = CMD_DECODE;
      row.pulse_width           = '0;
      row.typed                 = 1'b0;
      row.has_result            = 1'b0;
      row.result                = '0;
      return row;
   endfunction

   function automatic logic [WIDTH_W-1:0] pick_center();
      case ($urandom_range(0, 2))
         0:       return phase_cfg.short_center;
         1:       return phase_cfg.medium_center;
         default: return phase_cfg.long_center;
      endcase
   endfunction

   // Random width strictly inside the open window (the center when tolerance is zero), clamped to the field range
   function automatic logic [WIDTH_W-1:0] pulse_near(input logic [WIDTH_W-1:0] center,
                                                     input logic [WIDTH_W-1:0] tol);
      int p;
      if (tol <= 1) p = int'(center);
      else p = int'(center) - (int'(tol) - 1) + int'($urandom_range(0, 2 * int'(tol) - 2));
      if (p < 0) p = 0;
      if (p > 255) p = 255;
      return WIDTH_W'(p);
   endfunction

   // Sender: bursts of random length, random gap before each burst
   task automatic send_word(input command_type cmd, input logic [WIDTH_W-1:0] pw,
                            input bit typed, input bit has, input rsp_word_type word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.pulse_width <= pw;
      typed_hold          <= typed;
      typed_has           <= has;
      typed_word          <= word;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Wait out all expected words, then the pipeline tail for words with no result
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [WIDTH_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_windows(input window_cfg_type w);
      drain();
      write_reg(REG_SHORT_CENTER, w.short_center);
      write_reg(REG_MEDIUM_CENTER, w.medium_center);
      write_reg(REG_LONG_CENTER, w.long_center);
      write_reg(REG_TOLERANCE, w.tolerance);
      csr_bus.valid <= 1'b0;
      phase_cfg = w;
      window_loads++;
   endtask

   // Receiver: rotating stall pattern, redrawn whenever stall_left runs out
   logic [15:0] stall_pattern;
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left    = 64;
         stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      stall_left--;
      rsp_bus.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   // Monitor: check result words, track register writes, predict accepted words
   bit           produced;
   rsp_word_type predicted;
   rsp_word_type oldest;

   always @(posedge clock) begin
      if (reset) begin
         pred_windows   = '0;
         pred_phase_two = 1'b0;
         pred_bit_pos   = '0;
         pred_bit_buf   = '0;
         pred_pulses    = '0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_bus.read_error) errors_seen++;
            else bytes_seen++;
            if (expected_bytes.size() == 0) begin
               $error("result word with none expected: data_byte %02h pulse_count %0d err %0b",
                      rsp_bus.data_byte, rsp_bus.pulse_count, rsp_bus.read_error);
               failures++;
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_bus.data_byte !== oldest.data_byte) begin
                  $error("data_byte: expected %02h, actual %02h",
                         oldest.data_byte, rsp_bus.data_byte);
                  failures++;
               end
               if (rsp_bus.pulse_count !== oldest.pulse_count) begin
                  $error("pulse_count: expected %0d, actual %0d",
                         oldest.pulse_count, rsp_bus.pulse_count);
                  failures++;
               end
               if (rsp_bus.read_error !== oldest.read_error) begin
                  $error("read_error: expected %0b, actual %0b",
                         oldest.read_error, rsp_bus.read_error);
                  failures++;
               end
            end
         end

         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_index_type'(csr_bus.index))
               REG_SHORT_CENTER:  pred_windows.short_center  = csr_bus.data;
               REG_MEDIUM_CENTER: pred_windows.medium_center = csr_bus.data;
               REG_LONG_CENTER:   pred_windows.long_center   = csr_bus.data;
               REG_TOLERANCE:     pred_windows.tolerance     = csr_bus.data;
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            words_sent++;
            if (req_bus.command == CMD_RESTART) restarts_sent++;
            decode_pulse(req_bus.command, req_bus.pulse_width, produced, predicted);
            if (typed_hold) begin
               if (typed_has) expected_bytes.push_back(typed_word);
            end else if (produced) begin
               expected_bytes.push_back(predicted);
            end
         end
      end
   end

   // Watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tape_pulse_width_byte_decoder_unit regression: fail");
      $finish;
   end

   initial begin
      window_cfg_type          w;
      command_type             cmd;
      logic [WIDTH_W-1:0]      pw;
      logic [WIDTH_W-1:0]      center;
      int                      pick;
      int                      rim;

      req_bus.valid       = 1'b0;
      req_bus.command     = CMD_DECODE;
      req_bus.pulse_width = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = REG_SHORT_CENTER;
      csr_bus.data        = '0;
      typed_hold          = 1'b0;
      typed_has           = 1'b0;
      typed_word          = '0;
      phase_cfg           = '0;
      reset               = 1'b1;

      // Reset windows are empty: every pulse is a read error
      directed_rows.push_back(item_row(CMD_DECODE, 8'd0, 1'b1, 1'b1, 8'h00, 4'd0, 1'b1));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd255, 1'b1, 1'b1, 8'h00, 4'd0, 1'b1));
      directed_rows.push_back(item_row(CMD_RESTART, 8'd77, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd128, 1'b1, 1'b1, 8'h00, 4'd0, 1'b1));
      // Separate windows; four long pulses in phase one give 01010101
      directed_rows.push_back(window_row(8'd30, 8'd60, 8'd90, 8'd10));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd81, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd90, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd95, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd99, 1'b1, 1'b1, 8'h55, 4'd4, 1'b0));
      // Phase two path, an error mid byte, then a byte with a leftover bit
      directed_rows.push_back(item_row(CMD_DECODE, 8'd60, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd90, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd30, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd51, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd20, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd39, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd84, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      // Upper window bound is open
      directed_rows.push_back(item_row(CMD_DECODE, 8'd40, 1'b1, 1'b1, 8'h00, 4'd0, 1'b1));
      // Full overlap: long wins everywhere, window runs past both range ends
      directed_rows.push_back(window_row(8'd100, 8'd100, 8'd100, 8'd255));
      directed_rows.push_back(item_row(CMD_RESTART, 8'd0, 1'b1, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd255, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd255, 1'b1, 1'b1, 8'h55, 4'd4, 1'b0));
      // Narrow windows, short and medium at the range ends
      directed_rows.push_back(window_row(8'd0, 8'd255, 8'd128, 8'd1));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd1, 1'b1, 1'b1, 8'h00, 4'd0, 1'b1));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd0, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd255, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));
      directed_rows.push_back(item_row(CMD_DECODE, 8'd128, 1'b0, 1'b0, 8'h00, 4'd0, 1'b0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            load_windows(directed_rows[i].windows);
         end else begin
            send_word(directed_rows[i].command, directed_rows[i].pulse_width,
                      directed_rows[i].typed, directed_rows[i].has_result,
                      directed_rows[i].result);
         end
      end

      // Random phases, one window setting each
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 5)
            0, 1: begin
               w.tolerance     = WIDTH_W'($urandom_range(1, 24));
               w.short_center  = WIDTH_W'($urandom_range(0, 50));
               w.medium_center = WIDTH_W'(int'(w.short_center) + 2 * int'(w.tolerance)
                                          + int'($urandom_range(0, 30)));
               w.long_center   = WIDTH_W'(int'(w.medium_center) + 2 * int'(w.tolerance)
                                          + int'($urandom_range(0, 30)));
            end
            2: begin
               w.short_center  = 8'd0;
               w.medium_center = 8'd255;
               w.long_center   = WIDTH_W'($urandom_range(1, 254));
               w.tolerance     = WIDTH_W'($urandom_range(1, 3));
            end
            3: begin
               w.short_center  = WIDTH_W'($urandom_range(0, 255));
               w.medium_center = WIDTH_W'($urandom_range(0, 255));
               w.long_center   = WIDTH_W'($urandom_range(0, 255));
               w.tolerance     = WIDTH_W'($urandom_range(0, 255));
            end
            default: begin
               w.short_center  = WIDTH_W'($urandom_range(0, 255));
               w.medium_center = WIDTH_W'($urandom_range(0, 255));
               w.long_center   = WIDTH_W'($urandom_range(0, 255));
               w.tolerance     = (ph % 2 != 0) ? 8'd255 : 8'd0;
            end
         endcase
         load_windows(w);

         // mostly pulses that land in a window, some restarts, rims and noise
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pick = int'($urandom_range(0, 99));
            pw   = WIDTH_W'($urandom_range(0, 255));
            cmd  = CMD_DECODE;
            if (pick < 3) begin
               cmd = CMD_RESTART;
            end else if (pick < 8) begin
               center = pick_center();
               rim = $urandom_range(0, 1) ? int'(center) + int'(phase_cfg.tolerance)
                                          : int'(center) - int'(phase_cfg.tolerance);
               if (rim < 0) rim = 0;
               if (rim > 255) rim = 255;
               pw = WIDTH_W'(rim);
            end else if (pick >= 14) begin
               pw = pulse_near(pick_center(), phase_cfg.tolerance);
            end
            send_word(cmd, pw, 1'b0, 1'b0, '0);
         end
      end

      drain();
      repeat (FINAL_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d restarts) across %0d window settings",
               words_sent, restarts_sent, window_loads);
      $display("Checked %0d decoded bytes and %0d read errors, %0d mismatches",
               bytes_seen, errors_seen, failures);
      if (failures == 0 && expected_bytes.size() == 0) begin
         $display("tape_pulse_width_byte_decoder_unit regression: pass");
      end else begin
         if (expected_bytes.size() != 0)
            $error("%0d expected words never arrived", expected_bytes.size());
         $display("tape_pulse_width_byte_decoder_unit regression: fail");
      end
      $finish;
   end

endmodule
